/* hw/rtl/tss_pkg.sv */
// shared types, constants and the default schedule function for the slot schedule table
package tss_pkg;

  localparam int unsigned SLOTFRAME_LENGTH = 9;
  localparam int unsigned IDX_W = $clog2(SLOTFRAME_LENGTH);
  localparam int unsigned SLOT_W = 40;
  localparam int unsigned DIGIT_W = 8;
  localparam int unsigned MOD_STEPS = SLOT_W / DIGIT_W;
  localparam int unsigned STEP_W = $clog2(MOD_STEPS);
  localparam int unsigned ADDR_W = 64;
  localparam int unsigned CNT_W = 8;
  localparam int unsigned ID_W = 8;

  localparam logic [ADDR_W-1:0] ADDR_PREFIX = 64'h1415_9209_022B_0000;
  localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [CNT_W-1:0] COUNT_MAX = 8'hFF;

  localparam logic [ID_W-1:0] OWN_ID_RST = 8'h00;
  localparam logic [ID_W-1:0] MASTER_ID_RST = 8'h01;
  localparam logic [ID_W-1:0] SLAVE_ID_RST = 8'h02;
  localparam logic SCHED_MASTER_RST = (OWN_ID_RST == MASTER_ID_RST);
  localparam logic [ID_W-1:0] SCHED_PEER_RST = SCHED_MASTER_RST ? SLAVE_ID_RST : MASTER_ID_RST;

  typedef enum logic [1:0] {
    CMD_LOOKUP = 2'd0,
    CMD_REPORT = 2'd1,
    CMD_RELOAD = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    CFG_OWN_ID    = 2'd0,
    CFG_MASTER_ID = 2'd1,
    CFG_SLAVE_ID  = 2'd2
  } cfg_idx_e;

  typedef enum logic [2:0] {
    KIND_OFF      = 3'd0,
    KIND_ADV      = 3'd1,
    KIND_TX       = 3'd2,
    KIND_RX       = 3'd3,
    KIND_SERIALRX = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MOD,
    ST_EXEC
  } state_e;

  typedef struct packed {
    cmd_e              command;
    logic [SLOT_W-1:0] slot_number;
    logic              ack_received;
  } item_t;

  typedef struct packed {
    kind_e             cell_kind;
    logic [3:0]        channel_offset;
    logic              neighbor_kind;
    logic [ADDR_W-1:0] neighbor_address;
    logic [CNT_W-1:0]  uses_count;
    logic [CNT_W-1:0]  acked_count;
    logic [SLOT_W-1:0] last_used_slot;
  } result_t;

  typedef struct packed {
    kind_e             kind;
    logic              nb_kind;
    logic [ADDR_W-1:0] nb_addr;
  } cell_t;

  typedef struct packed {
    logic load;
    logic mod_step;
    logic exec;
  } ctrl_cmd_t;

  // default schedule cell for a given index and schedule snapshot
  function automatic cell_t cell_lookup(logic [IDX_W-1:0] idx, logic is_master,
                                        logic [ID_W-1:0] peer, logic [ID_W-1:0] slave);
    cell_t c;
    c.kind    = KIND_OFF;
    c.nb_kind = 1'b0;
    c.nb_addr = '0;
    case (idx)
      IDX_W'(0): begin
        c.kind = KIND_ADV;
      end
      IDX_W'(1): begin
        c.kind    = is_master ? KIND_TX : KIND_RX;
        c.nb_kind = 1'b1;
        c.nb_addr = {ADDR_PREFIX[ADDR_W-1:ID_W], peer};
      end
      IDX_W'(2): begin
        c.kind    = is_master ? KIND_RX : KIND_TX;
        c.nb_kind = 1'b1;
        c.nb_addr = {ADDR_PREFIX[ADDR_W-1:ID_W], peer};
      end
      IDX_W'(3): begin
        if (is_master) begin
          c.kind    = KIND_TX;
          c.nb_kind = 1'b1;
          c.nb_addr = {ADDR_PREFIX[ADDR_W-1:ID_W], slave};
        end
      end
      IDX_W'(4): begin
        if (is_master) begin
          c.kind    = KIND_RX;
          c.nb_kind = 1'b1;
          c.nb_addr = {ADDR_PREFIX[ADDR_W-1:ID_W], slave};
        end
      end
      IDX_W'(5): begin
        c.kind    = KIND_TX;
        c.nb_kind = 1'b1;
        c.nb_addr = ADDR_BROADCAST;
      end
      IDX_W'(6): begin
        c.kind = KIND_SERIALRX;
      end
      default: ;
    endcase
    return c;
  endfunction

endpackage

/* hw/rtl/tsch_slot_schedule_table_unit.sv */
// top level of the slotframe schedule table: controller plus datapath
// done_o is registered from the update state, as the result is; the result is taken at its end
// a transaction runs through the accept cycle, the 5-step byte-serial slot remainder and the update;
// busy stays high until the update is written, and a new start is taken only while busy is low
// reset: registers return to own 0, master 1, slave 2; default schedule rebuilt, counts zero
// done_o is a one-cycle strobe, the receiver cannot stall it; cfg writes are always taken
module tsch_slot_schedule_table_unit
  import tss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  item_t           item_i,
  output logic            done_o,
  output result_t         result_o,
  input  logic            cfg_valid_i,
  output logic            cfg_ready_o,
  input  cfg_idx_e        cfg_index_i,
  input  logic [ID_W-1:0] cfg_data_i
);

  ctrl_cmd_t ctrl_cmd;

  assign cfg_ready_o = 1'b1;

  tss_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (ctrl_cmd)
  );

  tss_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

/* hw/rtl/tss_ctrl.sv */
// controller state machine: sequences load, remainder steps and table update
module tss_ctrl
  import tss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  output logic      done_o,
  output ctrl_cmd_t cmd_o
);

  state_e            state_q, state_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              done_q, done_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      step_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      step_q  <= step_d;
      done_q  <= done_d;
    end
  end

  always_comb begin
    state_d = state_q;
    step_d  = step_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          step_d     = '0;
          state_d    = ST_MOD;
        end
      end
      ST_MOD: begin
        cmd_o.mod_step = 1'b1;
        if (step_q == STEP_W'(MOD_STEPS - 1)) begin
          state_d = ST_EXEC;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    done_d = cmd_o.exec;
  end

  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

endmodule

/* hw/rtl/tss_datapath.sv */
// datapath: config registers, byte-serial slot remainder, cell statistics and result register
module tss_datapath
  import tss_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  input  item_t           item_i,
  input  logic            cfg_valid_i,
  input  cfg_idx_e        cfg_index_i,
  input  logic [ID_W-1:0] cfg_data_i,
  output result_t         result_o
);

  logic [ID_W-1:0] own_q, master_q, slave_q;
  logic            sched_master_q, sched_master_d;
  logic [ID_W-1:0] sched_peer_q, sched_peer_d;
  logic [ID_W-1:0] sched_slave_q, sched_slave_d;

  cmd_e              cmd_q;
  logic              ack_q;
  logic [SLOT_W-1:0] slot_q;
  logic [IDX_W-1:0]  rem_q, rem_step;

  logic [CNT_W-1:0]  use_q [SLOTFRAME_LENGTH];
  logic [CNT_W-1:0]  ack_cnt_q [SLOTFRAME_LENGTH];
  logic [SLOT_W-1:0] last_q [SLOTFRAME_LENGTH];

  logic [CNT_W-1:0]  upd_use, upd_ack;
  logic [SLOT_W-1:0] upd_last;
  logic              new_master;
  cell_t             sched_cell;
  result_t           result_q, result_d;

  // config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_q    <= OWN_ID_RST;
      master_q <= MASTER_ID_RST;
      slave_q  <= SLAVE_ID_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_OWN_ID:    own_q    <= cfg_data_i;
        CFG_MASTER_ID: master_q <= cfg_data_i;
        CFG_SLAVE_ID:  slave_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // one byte of the slot number per step, msb first: r = (2r + bit) mod length
  always_comb begin
    logic [IDX_W:0] r;
    r = {1'b0, rem_q};
    for (int b = 0; b < DIGIT_W; b++) begin
      r = {r[IDX_W-1:0], slot_q[SLOT_W-1-b]};
      if (r >= (IDX_W+1)'(SLOTFRAME_LENGTH)) begin
        r = r - (IDX_W+1)'(SLOTFRAME_LENGTH);
      end
    end
    rem_step = r[IDX_W-1:0];
  end

  // slot register rotates a byte per step, so it holds the original value again at the end
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q  <= item_i.command;
      ack_q  <= item_i.ack_received;
      slot_q <= item_i.slot_number;
      rem_q  <= '0;
    end else if (cmd_i.mod_step) begin
      slot_q <= {slot_q[SLOT_W-DIGIT_W-1:0], slot_q[SLOT_W-1 -: DIGIT_W]};
      rem_q  <= rem_step;
    end
  end

  assign new_master = (own_q == master_q);

  always_comb begin
    sched_master_d = sched_master_q;
    sched_peer_d   = sched_peer_q;
    sched_slave_d  = sched_slave_q;
    upd_use        = use_q[rem_q];
    upd_ack        = ack_cnt_q[rem_q];
    upd_last       = last_q[rem_q];
    case (cmd_q)
      CMD_RELOAD: begin
        sched_master_d = new_master;
        sched_peer_d   = new_master ? slave_q : master_q;
        sched_slave_d  = slave_q;
        upd_use        = '0;
        upd_ack        = '0;
        upd_last       = '0;
      end
      CMD_REPORT: begin
        // saturating use count: halve both counts first
        if (upd_use == COUNT_MAX) begin
          upd_use = upd_use >> 1;
          upd_ack = upd_ack >> 1;
        end
        upd_use = upd_use + 1'b1;
        if (ack_q) begin
          upd_ack = upd_ack + 1'b1;
        end
        upd_last = slot_q;
      end
      default: ;
    endcase
    sched_cell = cell_lookup(rem_q, sched_master_d, sched_peer_d, sched_slave_d);
    result_d.cell_kind        = sched_cell.kind;
    result_d.channel_offset   = '0;
    result_d.neighbor_kind    = sched_cell.nb_kind;
    result_d.neighbor_address = sched_cell.nb_addr;
    result_d.uses_count       = upd_use;
    result_d.acked_count      = upd_ack;
    result_d.last_used_slot   = upd_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sched_master_q <= SCHED_MASTER_RST;
      sched_peer_q   <= SCHED_PEER_RST;
      sched_slave_q  <= SLAVE_ID_RST;
    end else if (cmd_i.exec) begin
      sched_master_q <= sched_master_d;
      sched_peer_q   <= sched_peer_d;
      sched_slave_q  <= sched_slave_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTFRAME_LENGTH; i++) begin
        use_q[i]     <= '0;
        ack_cnt_q[i] <= '0;
        last_q[i]    <= '0;
      end
    end else if (cmd_i.exec) begin
      if (cmd_q == CMD_RELOAD) begin
        for (int i = 0; i < SLOTFRAME_LENGTH; i++) begin
          use_q[i]     <= '0;
          ack_cnt_q[i] <= '0;
          last_q[i]    <= '0;
        end
      end else begin
        use_q[rem_q]     <= upd_use;
        ack_cnt_q[rem_q] <= upd_ack;
        last_q[rem_q]    <= upd_last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      result_q <= result_d;
    end
  end

  assign result_o = result_q;

endmodule

/* tb/tb.sv */
// self-checking testbench for the slotframe schedule table unit
module tb;
  import tss_pkg::*;

  localparam cmd_e CMD_SPARE = cmd_e'(2'd3);
  localparam cfg_idx_e CFG_SPARE = cfg_idx_e'(2'd3);
  localparam longint unsigned SLOT_MAX = 64'hFF_FFFF_FFFF;
  localparam int IDLE_LIMIT = 1000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  item_t item_i = '0;
  logic done_o;
  result_t result_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  cfg_idx_e cfg_index_i = CFG_OWN_ID;
  logic [ID_W-1:0] cfg_data_i = '0;

  tsch_slot_schedule_table_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .done_o      (done_o),
    .result_o    (result_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // predicted copy of the registers and the cell table
  logic [ID_W-1:0]   own_id, master_id, slave_id;
  kind_e             cell_kind_m [SLOTFRAME_LENGTH];
  logic              nb_kind_m   [SLOTFRAME_LENGTH];
  logic [ADDR_W-1:0] nb_addr_m   [SLOTFRAME_LENGTH];
  logic [CNT_W-1:0]  uses_m      [SLOTFRAME_LENGTH];
  logic [CNT_W-1:0]  acks_m      [SLOTFRAME_LENGTH];
  logic [SLOT_W-1:0] last_slot_m [SLOTFRAME_LENGTH];

  item_t   access_q[$];
  result_t pending_reports[$];

  int n_errors = 0;
  int n_items = 0;
  int n_reports = 0;
  int n_reloads = 0;
  int n_halvings = 0;
  int n_writes = 0;
  int n_results = 0;
  int gap_left = 0;
  int steady_left = 40;
  bit steady_run = 1'b0;
  int idle_cycles = 0;

  task automatic set_cell(input int idx, input kind_e kind, input logic has_nb,
                          input logic [ADDR_W-1:0] addr);
    cell_kind_m[idx] = kind;
    nb_kind_m[idx]   = has_nb;
    nb_addr_m[idx]   = has_nb ? addr : '0;
  endtask

  task automatic rebuild_schedule();
    logic is_master;
    logic [ADDR_W-1:0] peer_addr, slave_addr;
    is_master  = (own_id == master_id);
    peer_addr  = ADDR_PREFIX | ADDR_W'(is_master ? slave_id : master_id);
    slave_addr = ADDR_PREFIX | ADDR_W'(slave_id);
    for (int i = 0; i < SLOTFRAME_LENGTH; i++) begin
      set_cell(i, KIND_OFF, 1'b0, '0);
      uses_m[i]      = '0;
      acks_m[i]      = '0;
      last_slot_m[i] = '0;
    end
    set_cell(0, KIND_ADV, 1'b0, '0);
    set_cell(1, is_master ? KIND_TX : KIND_RX, 1'b1, peer_addr);
    set_cell(2, is_master ? KIND_RX : KIND_TX, 1'b1, peer_addr);
    if (is_master) begin
      set_cell(3, KIND_TX, 1'b1, slave_addr);
      set_cell(4, KIND_RX, 1'b1, slave_addr);
    end
    set_cell(5, KIND_TX, 1'b1, ADDR_BROADCAST);
    set_cell(6, KIND_SERIALRX, 1'b0, '0);
  endtask

  // applies one table access and returns the addressed cell as it then stands
  task automatic access_cell(input item_t it, output result_t r);
    int unsigned idx;
    idx = 32'(it.slot_number % SLOT_W'(SLOTFRAME_LENGTH));
    case (it.command)
      CMD_RELOAD: begin
        rebuild_schedule();
        n_reloads++;
      end
      CMD_REPORT: begin
        if (uses_m[idx] == COUNT_MAX) begin
          uses_m[idx] = uses_m[idx] >> 1;
          acks_m[idx] = acks_m[idx] >> 1;
          n_halvings++;
        end
        uses_m[idx] = uses_m[idx] + 1'b1;
        if (it.ack_received) acks_m[idx] = acks_m[idx] + 1'b1;
        last_slot_m[idx] = it.slot_number;
        n_reports++;
      end
      default: ;
    endcase
    r.cell_kind        = cell_kind_m[idx];
    r.channel_offset   = '0;
    r.neighbor_kind    = nb_kind_m[idx];
    r.neighbor_address = nb_kind_m[idx] ? nb_addr_m[idx] : '0;
    r.uses_count       = uses_m[idx];
    r.acked_count      = acks_m[idx];
    r.last_used_slot   = last_slot_m[idx];
  endtask

  function automatic item_t make_access(input cmd_e c, input longint unsigned s,
                                        input logic ack);
    item_t it;
    it.command      = c;
    it.slot_number  = SLOT_W'(s);
    it.ack_received = ack;
    return it;
  endfunction

  // random access, optionally aimed at one cell so its counters climb
  function automatic item_t random_access(input int focus, input int report_pct,
                                          input int reload_pct);
    item_t it;
    int r;
    longint unsigned s;
    r = $urandom_range(0, 99);
    if (r < report_pct) it.command = CMD_REPORT;
    else if (r < report_pct + reload_pct) it.command = CMD_RELOAD;
    else if (r < report_pct + reload_pct + 3) it.command = CMD_SPARE;
    else it.command = CMD_LOOKUP;
    case ($urandom_range(0, 9))
      0: s = $urandom_range(0, 30);
      1: s = SLOT_MAX - $urandom_range(0, 30);
      default: s = {24'd0, 8'($urandom), 32'($urandom)};
    endcase
    if (focus >= 0 && $urandom_range(0, 3) != 0) begin
      s = s - (s % SLOTFRAME_LENGTH) + focus;
      if (s > SLOT_MAX) s = s - SLOTFRAME_LENGTH;
    end
    it.slot_number  = SLOT_W'(s);
    it.ack_received = 1'($urandom);
    return it;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_run || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 8);
    return $urandom_range(20, 60);
  endfunction

  task automatic flag_field(input string name, input logic [ADDR_W-1:0] want,
                            input logic [ADDR_W-1:0] got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    n_errors++;
  endtask

  task automatic check_report(input result_t want, input result_t got);
    if (got.cell_kind !== want.cell_kind)
      flag_field("cell_kind", ADDR_W'(want.cell_kind), ADDR_W'(got.cell_kind));
    if (got.channel_offset !== want.channel_offset)
      flag_field("channel_offset", ADDR_W'(want.channel_offset),
                 ADDR_W'(got.channel_offset));
    if (got.neighbor_kind !== want.neighbor_kind)
      flag_field("neighbor_kind", ADDR_W'(want.neighbor_kind),
                 ADDR_W'(got.neighbor_kind));
    if (got.neighbor_address !== want.neighbor_address)
      flag_field("neighbor_address", want.neighbor_address, got.neighbor_address);
    if (got.uses_count !== want.uses_count)
      flag_field("uses_count", ADDR_W'(want.uses_count), ADDR_W'(got.uses_count));
    if (got.acked_count !== want.acked_count)
      flag_field("acked_count", ADDR_W'(want.acked_count), ADDR_W'(got.acked_count));
    if (got.last_used_slot !== want.last_used_slot)
      flag_field("last_used_slot", ADDR_W'(want.last_used_slot),
                 ADDR_W'(got.last_used_slot));
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [ID_W-1:0] data);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    n_writes++;
    case (idx)
      CFG_OWN_ID:    own_id = data;
      CFG_MASTER_ID: master_id = data;
      CFG_SLAVE_ID:  slave_id = data;
      default: ;
    endcase
  endtask

  // sender holds off until the table is idle and every result is in
  task automatic wait_drained();
    do @(negedge clk_i);
    while (access_q.size() != 0 || start || busy || pending_reports.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic queue_random(input int count, input int focus, input int report_pct,
                              input int reload_pct);
    repeat (count) access_q.push_back(random_access(focus, report_pct, reload_pct));
  endtask

  // driver: one access per start transaction, random gaps in between
  always @(posedge clk_i or negedge rst_ni) begin : driver
    result_t r;
    if (!rst_ni) begin
      start    <= 1'b0;
      item_i   <= '0;
      gap_left = 0;
    end else begin
      if (start && !busy) begin
        access_cell(item_i, r);
        pending_reports.push_back(r);
        n_items++;
        gap_left = pick_gap();
        steady_left--;
        if (steady_left <= 0) begin
          steady_run  = !steady_run;
          steady_left = $urandom_range(20, 100);
        end
      end
      if (start && busy) begin
        // hold the offered access
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left--;
      end else if (access_q.size() != 0) begin
        start  <= 1'b1;
        item_i <= access_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    result_t want;
    if (rst_ni && done_o) begin
      n_results++;
      if (pending_reports.size() == 0) begin
        $display("%0t: unexpected result 0x%0h", $time, result_o);
        n_errors++;
      end else begin
        want = pending_reports.pop_front();
        check_report(want, result_o);
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] v;
    own_id    = OWN_ID_RST;
    master_id = MASTER_ID_RST;
    slave_id  = SLAVE_ID_RST;
    rebuild_schedule();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: default slave schedule, every cell, slot extremes, all commands
    for (int k = 0; k < SLOTFRAME_LENGTH; k++)
      access_q.push_back(make_access(CMD_LOOKUP, k, k[0]));
    access_q.push_back(make_access(CMD_LOOKUP, SLOT_MAX, 1'b1));
    access_q.push_back(make_access(CMD_REPORT, SLOT_MAX, 1'b1));
    access_q.push_back(make_access(CMD_REPORT, SLOT_MAX - 9, 1'b0));
    access_q.push_back(make_access(CMD_REPORT, 9, 1'b1));
    access_q.push_back(make_access(CMD_SPARE, SLOT_MAX, 1'b1));
    access_q.push_back(make_access(CMD_SPARE, 1, 1'b0));
    access_q.push_back(make_access(CMD_REPORT, 64'h80_0000_0000, 1'b1));
    access_q.push_back(make_access(CMD_RELOAD, 0, 1'b0));
    access_q.push_back(make_access(CMD_LOOKUP, SLOT_MAX, 1'b0));
    access_q.push_back(make_access(CMD_REPORT, 64'h55_5555_5555, 1'b1));
    access_q.push_back(make_access(CMD_RELOAD, SLOT_MAX, 1'b1));
    access_q.push_back(make_access(CMD_LOOKUP, 64'h55_5555_5555, 1'b0));
    queue_random(250, -1, 35, 3);
    wait_drained();

    // master schedule with extreme ids; one cell hammered past count saturation
    write_reg(CFG_OWN_ID, 8'hFF);
    write_reg(CFG_MASTER_ID, 8'hFF);
    write_reg(CFG_SLAVE_ID, 8'h00);
    access_q.push_back(make_access(CMD_LOOKUP, 3, 1'b0));
    access_q.push_back(make_access(CMD_RELOAD, 4, 1'b0));
    queue_random(600, $urandom_range(0, SLOTFRAME_LENGTH - 1), 75, 0);
    wait_drained();

    // master with the other extremes, ignored write to a missing register
    write_reg(CFG_OWN_ID, 8'h00);
    write_reg(CFG_MASTER_ID, 8'h00);
    write_reg(CFG_SLAVE_ID, 8'hFF);
    write_reg(CFG_SPARE, 8'($urandom));
    access_q.push_back(make_access(CMD_LOOKUP, 1, 1'b1));
    access_q.push_back(make_access(CMD_RELOAD, 2, 1'b1));
    queue_random(250, -1, 40, 4);
    wait_drained();

    // slave with random ids
    v = 8'($urandom);
    write_reg(CFG_OWN_ID, v);
    write_reg(CFG_MASTER_ID, v ^ 8'($urandom_range(1, 255)));
    write_reg(CFG_SLAVE_ID, 8'($urandom));
    write_reg(CFG_SPARE, 8'($urandom));
    access_q.push_back(make_access(CMD_RELOAD, $urandom_range(0, 100), 1'b0));
    queue_random(250, $urandom_range(0, SLOTFRAME_LENGTH - 1), 45, 2);
    wait_drained();
    repeat (16) @(posedge clk_i);

    $display("%0d accesses: %0d use reports, %0d reloads, %0d count halvings",
             n_items, n_reports, n_reloads, n_halvings);
    $display("%0d register writes over four id settings, %0d results checked",
             n_writes, n_results);
    if (n_errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/tss_pkg.sv
hw/rtl/tss_ctrl.sv
hw/rtl/tss_datapath.sv
hw/rtl/tsch_slot_schedule_table_unit.sv
tb/tb.sv
